>>> rtl/core/huffman_code_bit_packer_top_macros.svh
// Assertion macros for the bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH

// Check a property at every clock edge outside reset.
`define HCBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property at every clock edge, reset included.
`define HCBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/core/hcbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int REQ_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  localparam int ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int SLEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int AW     = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

  localparam int PEND_W = BYTE_W - 1;
  localparam int CNT_W  = $clog2(BYTE_W);
  localparam int NEED_W = $clog2(BYTE_W + 1);

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SLEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [SLEN_W-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/hcbp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_front
  import hcbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic [CODE_W-1:0] code_bits,
  input  wire logic [LEN_W-1:0]  code_length,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  input  wire logic              q_full
);

  entry_t mem [SYMBOL_COUNT];
  entry_t rd;
  entry_t wr_entry;
  logic   s_valid;
  logic   s_flush;
  logic   accept;
  logic   in_range;
  logic   is_load;
  logic   is_enc;
  logic   is_flush;
  logic [ADDR_W-1:0] addr;

  assign full     = s_valid && q_full;
  assign accept   = push && !full;
  assign addr     = symbol[ADDR_W-1:0];
  assign in_range = int'(symbol) < SYMBOL_COUNT;
  assign is_load  = req_type == REQ_LOAD;
  assign is_enc   = req_type == REQ_ENCODE;
  assign is_flush = req_type == REQ_FLUSH;
  assign q_push   = s_valid && !q_full;

  always_comb begin
    wr_entry.code = code_bits;
    if (int'(code_length) > MAX_CODE_LEN) begin
      wr_entry.len = SLEN_W'(MAX_CODE_LEN);
    end else begin
      wr_entry.len = SLEN_W'(code_length);
    end
  end

  always_comb begin
    q_cmd.flush = s_flush;
    q_cmd.code  = rd.code;
    q_cmd.len   = rd.len;
  end

  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      mem[addr] <= wr_entry;
    end
    if (accept && is_enc) begin
      rd <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_flush <= is_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept && ((is_enc && in_range) || is_flush)) begin
      s_valid <= 1'b1;
    end else if (q_push) begin
      s_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hcbp_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_cmd_fifo
  import hcbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  cmd_t                slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] cnt;
  logic                do_push;
  logic                do_pop;

  assign full    = cnt == CQ_CNT_W'(CQ_DEPTH);
  assign empty   = cnt == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hcbp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_back
  import hcbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  cmd_t                   q_cmd,
  output logic                   empty,
  input  wire logic              pop,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   last_of_run
);

`include "huffman_code_bit_packer_top_macros.svh"

  logic              busy;
  logic              cur_flush;
  logic [AW-1:0]     aligned;
  logic [SLEN_W-1:0] rem;
  logic [PEND_W-1:0] pending_bits;
  logic [CNT_W-1:0]  pending_count;
  logic              out_valid;

  logic              out_free;
  logic [NEED_W-1:0] need;
  logic [BYTE_W-1:0] window;
  logic [BYTE_W-1:0] head;
  logic [BYTE_W-1:0] full_byte;
  logic [SLEN_W-1:0] rem_after;
  logic              emit_want;
  logic              step_go;
  logic              emit_go;
  logic              last_w;
  logic [BYTE_W-1:0] byte_w;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign q_pop    = !busy && !q_empty;

  assign need      = NEED_W'(BYTE_W) - NEED_W'(pending_count);
  assign window    = aligned[AW-1 -: BYTE_W];
  assign head      = BYTE_W'({1'b0, pending_bits} << need);
  assign full_byte = head | (window >> pending_count);
  assign rem_after = rem - SLEN_W'(need);

  always_comb begin
    if (cur_flush) begin
      emit_want = pending_count != '0;
      byte_w    = head;
      last_w    = 1'b1;
    end else begin
      emit_want = int'(rem) >= int'(need);
      byte_w    = full_byte;
      last_w    = int'(rem_after) < BYTE_W;
    end
  end

  assign step_go = busy && (!emit_want || out_free);
  assign emit_go = step_go && emit_want;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_flush <= q_cmd.flush;
      aligned   <= AW'(q_cmd.code) << (AW - int'(q_cmd.len));
      rem       <= q_cmd.len;
    end else if (step_go && !cur_flush && emit_want) begin
      aligned <= aligned << need;
      rem     <= rem_after;
    end
    if (emit_go) begin
      out_byte    <= byte_w;
      last_of_run <= last_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (step_go) begin
        if (emit_want) begin
          pending_bits  <= '0;
          pending_count <= '0;
          busy          <= !cur_flush && (rem_after != '0);
        end else begin
          if (!cur_flush) begin
            pending_bits  <= PEND_W'(full_byte >> (need - NEED_W'(rem)));
            pending_count <= pending_count + CNT_W'(rem);
          end
          busy <= 1'b0;
        end
      end
    end
  end

  `HCBP_ASSERT(a_flush_clears, busy && cur_flush && step_go |=> pending_count == '0, "flush left bits pending")
  `HCBP_ASSERT(a_more_bytes, emit_go && !cur_flush && !last_w |=> busy, "item ended before its last byte")
  `HCBP_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !out_valid, "packer not idle after reset")

endmodule

`default_nettype wire

>>> rtl/core/huffman_code_bit_packer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Huffman bit packer: a 256-entry code table feeding a byte packer.
// Input queue side: push/full carry req_type, symbol, code_bits, code_length.
//   A load item writes one table entry; an encode item appends the symbol's
//   code MSB first; a flush item pads a partial byte with zeros.
// Result queue side: empty/pop carry out_byte and last_of_run; last_of_run
//   marks the final byte of an item.
// An encode or flush goes through the table-read stage, a command queue write,
//   a command fetch and a packer step before its first byte shows.
// Packer: it fetches each command, then takes one step per output byte and one
//   more step if bits are left over (a single step if no byte completes), and
//   fetches the next command only after the last step of the current one.
//   Loads finish in the table-read stage and take no packer time.
// A four-entry command queue lets the front keep taking items while the
//   packer works; full rises once it and the table-read stage are both full.
// When pop stays low the finished byte holds and the packer stalls before emitting another byte.
// Reset empties both queues and clears the pending bits; table entries are
//   undefined until loaded.

module huffman_code_bit_packer_top
  import hcbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [REQ_W-1:0]  req_type,
  input  wire logic [SYM_W-1:0]  symbol,
  input  wire logic [CODE_W-1:0] code_bits,
  input  wire logic [LEN_W-1:0]  code_length,
  output logic                   empty,
  input  wire logic              pop,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   last_of_run
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_out;

  hcbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .q_push      (q_push),
    .q_cmd       (q_in),
    .q_full      (q_full)
  );

  hcbp_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .empty    (q_empty)
  );

  hcbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_cmd       (q_out),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
